FILE: hdl/cdt3_pkg.sv
// ----------------------------------------------------------------------------
// cdt3_pkg: shared types and constants
// Command codes, register indexes and value widths of the chamfer block.
// ----------------------------------------------------------------------------
package cdt3_pkg;

    // grid side in voxels, fixed by the 4-bit voxel address ports
    localparam int MAX_SIDE = 16;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_RUN  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [2:0] REG_SIZE_X = 3'd0;
    localparam logic [2:0] REG_SIZE_Y = 3'd1;
    localparam logic [2:0] REG_SIZE_Z = 3'd2;
    localparam logic [2:0] REG_FACE   = 3'd3;
    localparam logic [2:0] REG_EDGE   = 3'd4;
    localparam logic [2:0] REG_CORNER = 3'd5;
    localparam logic [2:0] REG_FAR    = 3'd6;

    typedef logic [15:0] t_dist;

endpackage

FILE: hdl/chamfer_distance_transform_3d.sv
// ----------------------------------------------------------------------------
// chamfer_distance_transform_3d
// Voxel grid of Q8.8 distances with a two-pass 3-D chamfer relaxation.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (i_valid / o_stall) carry a command and a voxel address.
//   A load writes one voxel, a read returns it on the output channel
//   (o_valid / i_stall), a run performs a forward then a backward raster
//   pass over the extent in use. Every item yields one result item.
//   Loads and reads take one item per cycle while the output register can
//   take their results; a read result passes the memory read register and
//   then the output register.
//   A run holds intake for each voxel of the extent per pass: 14 reads of
//   the single memory read port, then one write of the relaxed distance.
//   Reset clears the control state and loads register defaults; the grid
//   contents stay undefined until loaded. When the receiver stalls, a
//   finished result waits in the output register and intake stops once
//   that register is full and another result is due.
//   Configuration writes are always ready.
// ----------------------------------------------------------------------------
module chamfer_distance_transform_3d
    import cdt3_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [3:0]  i_voxel_x,
    input  logic [3:0]  i_voxel_y,
    input  logic [3:0]  i_voxel_z,
    input  logic [15:0] i_load_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_read_value,
    output logic        o_was_read,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_SIDE);
    localparam int MW = 3 * AW;
    localparam int SW = $clog2(MAX_SIDE + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_WR   = 3'd2;
    localparam logic [2:0] ST_DONE = 3'd3;

    // configuration registers
    logic [4:0]  r_size_x, r_size_y, r_size_z;
    logic [11:0] r_face, r_edge, r_corner;
    t_dist       r_far;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= 5'd16;
            r_size_y <= 5'd16;
            r_size_z <= 5'd16;
            r_face   <= 12'd256;
            r_edge   <= 12'd362;
            r_corner <= 12'd443;
            r_far    <= 16'hFFFF;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SIZE_X: r_size_x <= i_cfg_data[4:0];
                REG_SIZE_Y: r_size_y <= i_cfg_data[4:0];
                REG_SIZE_Z: r_size_z <= i_cfg_data[4:0];
                REG_FACE:   r_face   <= i_cfg_data[11:0];
                REG_EDGE:   r_edge   <= i_cfg_data[11:0];
                REG_CORNER: r_corner <= i_cfg_data[11:0];
                REG_FAR:    r_far    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective extent, clipped to the grid side
    function automatic logic [SW-1:0] f_eff(input logic [4:0] s);
        logic [SW:0] m;
        m = (SW + 1)'(MAX_SIDE);
        if ({{(SW + 1 > 5 ? SW + 1 - 5 : 0){1'b0}}, s} > m) return SW'(MAX_SIDE);
        return SW'(s);
    endfunction

    logic [SW-1:0] w_nx, w_ny, w_nz;
    assign w_nx = f_eff(r_size_x);
    assign w_ny = f_eff(r_size_y);
    assign w_nz = f_eff(r_size_z);

    // grid memory, read data held while a result waits for the output register
    t_dist   r_mem [MAX_SIDE*MAX_SIDE*MAX_SIDE];
    logic    w_we;
    logic    w_hold;
    logic [MW-1:0] w_waddr, w_raddr;
    t_dist   w_wdata, r_rdata;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        if (!w_hold) r_rdata <= r_mem[w_raddr];
    end

    // sweep state
    logic [2:0]    r_st;
    logic          r_bwd;
    logic [AW-1:0] r_x, r_y, r_z;
    logic [3:0]    r_k;        // read slot: 0 self, 1..13 neighbours
    logic          r_rv;       // data of previous read slot arrives now
    logic [3:0]    r_kp;
    logic          r_inb_p;
    logic [1:0]    r_steps_p;
    t_dist         r_best;

    // output register and pending read pipe
    logic  r_ov, r_pend, r_pend_rd, r_pend_in;
    t_dist r_oval;
    logic  r_owr;

    logic w_out_free, w_accept;
    assign w_out_free = !r_ov || !i_stall;
    assign w_hold     = r_pend && !w_out_free;
    assign o_stall    = (r_st != ST_IDLE) || (r_pend && !w_out_free);
    assign w_accept   = i_valid && !o_stall;

    // neighbour offsets, forward half; backward is negated
    logic signed [1:0] w_dx, w_dy, w_dz;
    always_comb begin
        unique case (r_k)
            4'd1:  {w_dx, w_dy, w_dz} = { 2'sd0,  2'sd0, -2'sd1};
            4'd2:  {w_dx, w_dy, w_dz} = { 2'sd0, -2'sd1, -2'sd1};
            4'd3:  {w_dx, w_dy, w_dz} = { 2'sd0, -2'sd1,  2'sd0};
            4'd4:  {w_dx, w_dy, w_dz} = { 2'sd0, -2'sd1,  2'sd1};
            4'd5:  {w_dx, w_dy, w_dz} = {-2'sd1, -2'sd1, -2'sd1};
            4'd6:  {w_dx, w_dy, w_dz} = {-2'sd1, -2'sd1,  2'sd0};
            4'd7:  {w_dx, w_dy, w_dz} = {-2'sd1, -2'sd1,  2'sd1};
            4'd8:  {w_dx, w_dy, w_dz} = {-2'sd1,  2'sd0, -2'sd1};
            4'd9:  {w_dx, w_dy, w_dz} = {-2'sd1,  2'sd0,  2'sd0};
            4'd10: {w_dx, w_dy, w_dz} = {-2'sd1,  2'sd0,  2'sd1};
            4'd11: {w_dx, w_dy, w_dz} = {-2'sd1,  2'sd1, -2'sd1};
            4'd12: {w_dx, w_dy, w_dz} = {-2'sd1,  2'sd1,  2'sd0};
            4'd13: {w_dx, w_dy, w_dz} = {-2'sd1,  2'sd1,  2'sd1};
            default: {w_dx, w_dy, w_dz} = 6'd0;
        endcase
    end

    // neighbour coordinate and bounds
    logic signed [AW+1:0] w_px, w_py, w_pz, w_sx, w_sy, w_sz;
    logic w_inb;
    logic [1:0] w_steps;
    always_comb begin
        w_sx = r_bwd ? -(AW+2)'(w_dx) : (AW+2)'(w_dx);
        w_sy = r_bwd ? -(AW+2)'(w_dy) : (AW+2)'(w_dy);
        w_sz = r_bwd ? -(AW+2)'(w_dz) : (AW+2)'(w_dz);
        w_px = $signed({2'b00, r_x}) + w_sx;
        w_py = $signed({2'b00, r_y}) + w_sy;
        w_pz = $signed({2'b00, r_z}) + w_sz;
        w_inb = (w_px >= 0) && (w_px < $signed({1'b0, w_nx}))
             && (w_py >= 0) && (w_py < $signed({1'b0, w_ny}))
             && (w_pz >= 0) && (w_pz < $signed({1'b0, w_nz}));
        w_steps = 2'((w_dx != 0) + (w_dy != 0) + (w_dz != 0));
    end

    // candidate from arriving neighbour data
    logic [16:0] w_sum;
    t_dist w_cand, w_self;
    logic [11:0] w_wt;
    always_comb begin
        w_wt = (r_steps_p == 2'd1) ? r_face : (r_steps_p == 2'd2) ? r_edge : r_corner;
        w_sum = {1'b0, r_rdata} + {5'd0, w_wt};
        w_cand = w_sum[16] ? 16'hFFFF : w_sum[15:0];
        w_self = (r_rdata > r_far) ? r_far : r_rdata;
    end

    // voxel address of input item
    logic w_inside;
    assign w_inside = ({4'd0, i_voxel_x} < 8'(MAX_SIDE)) && ({4'd0, i_voxel_y} < 8'(MAX_SIDE))
                   && ({4'd0, i_voxel_z} < 8'(MAX_SIDE));

    // memory port selection
    always_comb begin
        w_we    = 1'b0;
        w_waddr = {r_x, r_y, r_z};
        w_wdata = r_best;
        w_raddr = {r_x, r_y, r_z};
        if (r_st == ST_WR) begin
            w_we = 1'b1;
            // fold in the final neighbour read that arrives this cycle
            if (r_rv && w_cand < r_best) w_wdata = w_cand;
        end else if (r_st == ST_RD) begin
            if (r_k != 4'd0)
                w_raddr = {w_px[AW-1:0], w_py[AW-1:0], w_pz[AW-1:0]};
        end else begin
            w_waddr = {i_voxel_x[AW-1:0], i_voxel_y[AW-1:0], i_voxel_z[AW-1:0]};
            w_wdata = i_load_value;
            w_raddr = w_waddr;
            w_we    = w_accept && (i_cmd == CMD_LOAD) && w_inside;
        end
    end

    // last voxel of a pass
    logic w_last;
    assign w_last = r_bwd ? (r_x == 0 && r_y == 0 && r_z == 0)
        : (r_x == AW'(w_nx - 1'b1) && r_y == AW'(w_ny - 1'b1)
           && r_z == AW'(w_nz - 1'b1));

    // sequencer and output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_ov <= 1'b0; r_pend <= 1'b0; r_rv <= 1'b0;
            r_bwd <= 1'b0; r_k <= '0; r_x <= '0; r_y <= '0; r_z <= '0;
        end else begin
            if (r_ov && !i_stall) r_ov <= 1'b0;
            if (r_pend && w_out_free) begin
                r_ov   <= 1'b1;
                r_owr  <= r_pend_rd;
                r_oval <= (r_pend_rd && r_pend_in) ? r_rdata : 16'd0;
                r_pend <= 1'b0;
            end
            r_rv <= 1'b0;
            unique case (r_st)
                ST_IDLE: if (w_accept) begin
                    r_pend <= 1'b1;
                    r_pend_rd <= (i_cmd == CMD_READ);
                    r_pend_in <= w_inside;
                    if (i_cmd == CMD_RUN) begin
                        r_pend <= 1'b0;
                        r_bwd <= 1'b0; r_x <= '0; r_y <= '0; r_z <= '0; r_k <= '0;
                        r_st <= (w_nx == 0 || w_ny == 0 || w_nz == 0) ? ST_DONE : ST_RD;
                    end
                end
                ST_RD: begin
                    r_rv <= (r_k == 0) || w_inb;
                    r_kp <= r_k; r_steps_p <= w_steps;
                    if (r_k == 4'd13) begin
                        r_k <= '0; r_st <= ST_WR;
                    end else r_k <= r_k + 1'b1;
                    if (r_rv) r_best <= (r_kp == 0) ? w_self
                        : ((w_cand < r_best) ? w_cand : r_best);
                end
                ST_WR: begin
                    // the same cycle folds in the final neighbour read
                    if (r_rv && w_cand < r_best) r_best <= w_cand;
                    r_st <= ST_RD;
                    if (w_last) begin
                        if (r_bwd) r_st <= ST_DONE;
                        else begin
                            r_bwd <= 1'b1;
                            r_x <= AW'(w_nx - 1'b1); r_y <= AW'(w_ny - 1'b1);
                            r_z <= AW'(w_nz - 1'b1);
                        end
                    end else if (!r_bwd) begin
                        if (r_z != AW'(w_nz - 1'b1)) r_z <= r_z + 1'b1;
                        else begin
                            r_z <= '0;
                            if (r_y != AW'(w_ny - 1'b1)) r_y <= r_y + 1'b1;
                            else begin r_y <= '0; r_x <= r_x + 1'b1; end
                        end
                    end else begin
                        if (r_z != 0) r_z <= r_z - 1'b1;
                        else begin
                            r_z <= AW'(w_nz - 1'b1);
                            if (r_y != 0) r_y <= r_y - 1'b1;
                            else begin r_y <= AW'(w_ny - 1'b1); r_x <= r_x - 1'b1; end
                        end
                    end
                end
                ST_DONE: if (!r_ov || !i_stall) begin
                    r_ov <= 1'b1; r_owr <= 1'b0; r_oval <= 16'd0; r_st <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign o_valid      = r_ov;
    assign o_read_value = r_oval;
    assign o_was_read   = r_owr;

    // checks
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_RD || r_st == ST_WR) |-> o_stall) else $error("intake open during sweep");
    a_wr_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_WR) |=> (r_st != ST_WR)) else $error("double write");
    a_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_was_read) |-> (o_read_value == 16'd0)) else $error("nonzero value");

endmodule

FILE: bench/chamfer_distance_transform_3d_chk.sv
// ----------------------------------------------------------------------------
// chamfer_distance_transform_3d_chk: result checker
// Watches the item, result and register channels of the chamfer block, keeps
// its own copy of the voxel grid and the registers, predicts every result
// and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module chamfer_distance_transform_3d_chk
    import cdt3_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [3:0]  i_voxel_x,
    input  logic [3:0]  i_voxel_y,
    input  logic [3:0]  i_voxel_z,
    input  logic [15:0] i_load_value,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [15:0] i_read_value,
    input  logic        i_was_read,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int SIDE = 16;

    typedef struct packed {
        t_dist value;
        logic  rd;
    } t_voxel_answer;

    // forward half-neighbourhood, the backward one is its negation
    localparam int OFS_X [13] = '{ 0,  0,  0,  0, -1, -1, -1, -1, -1, -1, -1, -1, -1};
    localparam int OFS_Y [13] = '{ 0, -1, -1, -1, -1, -1, -1,  0,  0,  0,  1,  1,  1};
    localparam int OFS_Z [13] = '{-1, -1,  0,  1, -1,  0,  1, -1,  0,  1, -1,  0,  1};

    t_dist         dist_mem [SIDE*SIDE*SIDE];
    t_voxel_answer answer_q [$];
    logic [4:0]    ext_x, ext_y, ext_z;
    logic [11:0]   w_face, w_edge, w_corner;
    t_dist         ceiling;

    function automatic int vox_addr(int x, int y, int z);
        return (x * SIDE + y) * SIDE + z;
    endfunction

    function automatic int clip_side(logic [4:0] s);
        return (s > SIDE) ? SIDE : int'(s);
    endfunction

    // relax one voxel against its in-bounds half-neighbourhood
    task automatic relax_voxel(int x, int y, int z, int sgn, int nx, int ny, int nz);
        int best, px, py, pz, steps, w, v;
        best = dist_mem[vox_addr(x, y, z)];
        if (best > ceiling) best = ceiling;
        for (int k = 0; k < 13; k++) begin
            px = x + sgn * OFS_X[k];
            py = y + sgn * OFS_Y[k];
            pz = z + sgn * OFS_Z[k];
            if (px < 0 || px >= nx || py < 0 || py >= ny || pz < 0 || pz >= nz) continue;
            steps = (OFS_X[k] != 0) + (OFS_Y[k] != 0) + (OFS_Z[k] != 0);
            w = (steps == 1) ? w_face : ((steps == 2) ? w_edge : w_corner);
            v = dist_mem[vox_addr(px, py, pz)] + w;
            if (v > 65535) v = 65535;
            if (v < best) best = v;
        end
        dist_mem[vox_addr(x, y, z)] = t_dist'(best);
    endtask

    // forward raster sweep, then backward, updated in place
    task automatic chamfer_sweeps();
        int nx, ny, nz;
        nx = clip_side(ext_x);
        ny = clip_side(ext_y);
        nz = clip_side(ext_z);
        for (int x = 0; x < nx; x++)
            for (int y = 0; y < ny; y++)
                for (int z = 0; z < nz; z++)
                    relax_voxel(x, y, z, 1, nx, ny, nz);
        for (int x = nx - 1; x >= 0; x--)
            for (int y = ny - 1; y >= 0; y--)
                for (int z = nz - 1; z >= 0; z--)
                    relax_voxel(x, y, z, -1, nx, ny, nz);
    endtask

    task automatic report(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_voxel_answer exp_item;
        t_voxel_answer new_item;
        if (!i_rst_n) begin
            ext_x    <= 5'd16;
            ext_y    <= 5'd16;
            ext_z    <= 5'd16;
            w_face   <= 12'd256;
            w_edge   <= 12'd362;
            w_corner <= 12'd443;
            ceiling  <= 16'hFFFF;
        end else begin
            // compare a returned result with the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                if (answer_q.size() == 0) begin
                    report("unexpected result, read_value", i_read_value, 0);
                end else begin
                    exp_item = answer_q.pop_front();
                    if (i_read_value !== exp_item.value)
                        report("read_value", i_read_value, exp_item.value);
                    if (i_was_read !== exp_item.rd)
                        report("was_read", i_was_read, exp_item.rd);
                end
            end
            // predict the result of an accepted item
            if (i_valid && !i_in_stall) begin
                new_item = '0;
                case (i_cmd)
                    CMD_LOAD: dist_mem[vox_addr(i_voxel_x, i_voxel_y, i_voxel_z)] = i_load_value;
                    CMD_RUN:  chamfer_sweeps();
                    CMD_READ: begin
                        new_item.value = dist_mem[vox_addr(i_voxel_x, i_voxel_y, i_voxel_z)];
                        new_item.rd    = 1'b1;
                    end
                    default: ;
                endcase
                answer_q.push_back(new_item);
            end
            // register copy
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_SIZE_X: ext_x    <= i_cfg_data[4:0];
                    REG_SIZE_Y: ext_y    <= i_cfg_data[4:0];
                    REG_SIZE_Z: ext_z    <= i_cfg_data[4:0];
                    REG_FACE:   w_face   <= i_cfg_data[11:0];
                    REG_EDGE:   w_edge   <= i_cfg_data[11:0];
                    REG_CORNER: w_corner <= i_cfg_data[11:0];
                    REG_FAR:    ceiling  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = answer_q.size();
    end

endmodule

FILE: bench/chamfer_distance_transform_3d_tb.sv
// ----------------------------------------------------------------------------
// chamfer_distance_transform_3d_tb: testbench top
// Runs the chamfer block through a series of register settings: each phase
// loads the whole extent, then mixes random loads, reads, runs and unused
// commands with random gaps and stalls outside the quiet phases. A checker module predicts results.
// ----------------------------------------------------------------------------
module chamfer_distance_transform_3d_tb;
    import cdt3_pkg::*;

    localparam int SIDE        = 16;
    localparam int NUM_PHASES  = 11;
    localparam int MIX_ITEMS   = 140;
    localparam int CYCLE_LIMIT = 1500000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_cmd = CMD_LOAD;
    logic [3:0]  i_voxel_x = '0;
    logic [3:0]  i_voxel_y = '0;
    logic [3:0]  i_voxel_z = '0;
    logic [15:0] i_load_value = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_read_value;
    logic        o_was_read;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = REG_SIZE_X;
    logic [15:0] i_cfg_data = '0;

    int          fail_count;
    int          pending;
    int          cycle_cnt = 0;
    int          stall_left = 0;
    logic        quiet = 1'b0;
    logic        loaded [SIDE*SIDE*SIDE];
    int          loaded_list [$];
    int          n_items = 0;
    int          n_reads = 0;
    int          n_runs = 0;

    always #6 i_clk = ~i_clk;

    chamfer_distance_transform_3d dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_voxel_x    (i_voxel_x),
        .i_voxel_y    (i_voxel_y),
        .i_voxel_z    (i_voxel_z),
        .i_load_value (i_load_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_read_value (o_read_value),
        .o_was_read   (o_was_read),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    chamfer_distance_transform_3d_chk chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_in_stall   (o_stall),
        .i_cmd        (i_cmd),
        .i_voxel_x    (i_voxel_x),
        .i_voxel_y    (i_voxel_y),
        .i_voxel_z    (i_voxel_z),
        .i_load_value (i_load_value),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_read_value (o_read_value),
        .i_was_read   (o_was_read),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side stall: a random wait drawn for every result
    always @(posedge i_clk) begin
        int n;
        if (i_rst_n) begin
            if (i_stall) begin
                if (stall_left <= 1) i_stall <= 1'b0;
                stall_left <= stall_left - 1;
            end else if (o_valid) begin
                n = quiet ? 0 : $urandom_range(0, 3);
                if (n > 0) i_stall <= 1'b1;
                stall_left <= n;
            end
        end
    end

    // send one item after a random gap and wait until it is taken
    task automatic send_item(logic [1:0] cmd, int x, int y, int z, logic [15:0] val);
        int gap;
        int a;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_voxel_x    <= x[3:0];
        i_voxel_y    <= y[3:0];
        i_voxel_z    <= z[3:0];
        i_load_value <= val;
        do @(posedge i_clk); while (o_stall);
        n_items++;
        if (cmd == CMD_READ) n_reads++;
        if (cmd == CMD_RUN) n_runs++;
        if (cmd == CMD_LOAD) begin
            a = (x * SIDE + y) * SIDE + z;
            if (!loaded[a]) begin
                loaded[a] = 1'b1;
                loaded_list.push_back(a);
            end
        end
    endtask

    task automatic read_loaded();
        int a;
        a = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
        send_item(CMD_READ, a / (SIDE*SIDE), (a / SIDE) % SIDE, a % SIDE,
                  16'($urandom));
    endtask

    // write all registers back to back, then drop valid
    task automatic write_regs(int sx, int sy, int sz, int fw, int ew, int cw, int far_v);
        int vals [7];
        logic [2:0] idx [7];
        vals = '{sx, sy, sz, fw, ew, cw, far_v};
        idx  = '{REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z, REG_FACE, REG_EDGE, REG_CORNER,
                 REG_FAR};
        for (int i = 0; i < 7; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= vals[i][15:0];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [15:0] seed_value();
        return ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 2047))
                                           : 16'($urandom);
    endfunction

    // fill the extent in use so a run never touches an unloaded voxel
    task automatic fill_extent(int sx, int sy, int sz);
        int nx, ny, nz;
        nx = (sx > SIDE) ? SIDE : sx;
        ny = (sy > SIDE) ? SIDE : sy;
        nz = (sz > SIDE) ? SIDE : sz;
        for (int x = 0; x < nx; x++)
            for (int y = 0; y < ny; y++)
                for (int z = 0; z < nz; z++)
                    send_item(CMD_LOAD, x, y, z, seed_value());
    endtask

    // random mix of loads, reads, runs and the unused command
    task automatic random_mix(int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40)
                send_item(CMD_LOAD, $urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom_range(0, 15), seed_value());
            else if (r < 88)
                read_loaded();
            else if (r < 94)
                send_item(CMD_RUN, $urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom_range(0, 15), 16'($urandom));
            else
                send_item(2'd3, $urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom_range(0, 15), 16'($urandom));
        end
    endtask

    initial begin
        int cfg_tab [NUM_PHASES][7];
        cfg_tab = '{
            '{ 2,  2,  2,  256,  362,  443, 65535},
            '{16,  1,  1,  256,  362,  443, 65535},
            '{ 1, 16,  1,    0,    0,    0, 65535},
            '{ 1,  1, 16, 4095, 4095, 4095, 65535},
            '{ 3,  3,  3,  256,  362,  443,  1000},
            '{ 4,  3,  2, 4095,    0, 4095,     0},
            '{ 0,  5,  5,  100,  200,  300, 65535},
            '{31,  2,  1,  256,  362,  443, 30000},
            '{ 4,  4,  4,    1,    2,    3, 65535},
            '{ 2, 16,  2,  256,  362,  443, 65535},
            '{ 5,  5,  5,  300,  420,  520, 40000}
        };
        for (int i = 0; i < SIDE*SIDE*SIDE; i++) loaded[i] = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < NUM_PHASES; p++) begin
            quiet = (p % 4 == 3);
            if (p >= 8) begin
                cfg_tab[p][3] = $urandom_range(0, 4095);
                cfg_tab[p][4] = $urandom_range(0, 4095);
                cfg_tab[p][5] = $urandom_range(0, 4095);
                cfg_tab[p][6] = $urandom_range(0, 65535);
            end
            write_regs(cfg_tab[p][0], cfg_tab[p][1], cfg_tab[p][2], cfg_tab[p][3],
                       cfg_tab[p][4], cfg_tab[p][5], cfg_tab[p][6]);
            if (p == 0) begin
                // directed: value and address extremes, every command
                send_item(CMD_LOAD, 0, 0, 0, 16'h0000);
                send_item(CMD_LOAD, 0, 0, 1, 16'hFFFF);
                send_item(CMD_LOAD, 0, 1, 0, 16'hFFFF);
                send_item(CMD_LOAD, 0, 1, 1, 16'hFFFF);
                send_item(CMD_LOAD, 1, 0, 0, 16'hFFFF);
                send_item(CMD_LOAD, 1, 0, 1, 16'hFFFF);
                send_item(CMD_LOAD, 1, 1, 0, 16'hFFFF);
                send_item(CMD_LOAD, 1, 1, 1, 16'h5A5A);
                // outside the extent but inside the grid
                send_item(CMD_LOAD, 15, 15, 15, 16'hA5A5);
                send_item(CMD_LOAD, 15, 0, 7, 16'h0001);
                send_item(CMD_READ, 15, 15, 15, 16'h0);
                send_item(CMD_READ, 15, 0, 7, 16'hFFFF);
                send_item(2'd3, 15, 15, 15, 16'hFFFF);
                send_item(CMD_RUN, 0, 0, 0, 16'h0);
                for (int a = 0; a < 8; a++)
                    send_item(CMD_READ, a / 4, (a / 2) % 2, a % 2, 16'h0);
                send_item(CMD_READ, 15, 15, 15, 16'h0);
            end else begin
                fill_extent(cfg_tab[p][0], cfg_tab[p][1], cfg_tab[p][2]);
            end
            random_mix(MIX_ITEMS);
            wait_idle();
        end

        $display("covered %0d items over %0d register settings: %0d reads, %0d runs",
                 n_items, NUM_PHASES, n_reads, n_runs);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: chamfer_distance_transform_3d.f
hdl/cdt3_pkg.sv
hdl/chamfer_distance_transform_3d.sv
bench/chamfer_distance_transform_3d_chk.sv
bench/chamfer_distance_transform_3d_tb.sv
